[rtl/number_literal_lexer_top_defines.svh]
// Assertion helpers shared by the lexer modules.
`ifndef NUMBER_LITERAL_LEXER_TOP_DEFINES_SVH
`define NUMBER_LITERAL_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define NLL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define NLL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/nll_pkg.sv]
`timescale 1ns / 1ps

package nll_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef struct packed {
		logic       start_req;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [1:0]  kind;
		logic [63:0] value;
	} res_t;

	typedef struct packed {
		logic       start;
		logic [7:0] lower;
		logic       is_dec;
		logic       hex_ok;
		logic [3:0] dval;
		logic       is_minus;
		logic       is_plus;
		logic       is_dot;
	} cls_t;

	typedef struct packed {
		logic valid;
		cls_t cls;
	} qslot_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SIGN, PH_ZERO, PH_PFX, PH_PDIG, PH_DEC, PH_FRAC0, PH_FRAC,
		PH_EXP, PH_ESGN, PH_EDIG, PH_EXP0, PH_ESGN0, PH_EDIG0, PH_NAN, PH_INF
	} phase_t;

	typedef enum logic [1:0] {RX_DEC, RX_BIN, RX_OCT, RX_HEX} radix_t;

	localparam logic [3:0] ST_OK    = 4'd0;
	localparam logic [3:0] ST_LEADZ = 4'd1;
	localparam logic [3:0] ST_MINUS = 4'd5;
	localparam logic [3:0] ST_DIGIT = 4'd6;
	localparam logic [3:0] ST_EXP   = 4'd7;
	localparam logic [3:0] ST_RANGE = 4'd8;

	localparam logic [1:0] KIND_INVALID  = 2'd0;
	localparam logic [1:0] KIND_UNSIGNED = 2'd1;
	localparam logic [1:0] KIND_SIGNED   = 2'd2;
	localparam logic [1:0] KIND_FLOAT    = 2'd3;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_I     = 8'h69;

	localparam logic [3:0] NAN_LEN   = 4'd3;
	localparam logic [3:0] INF_SHORT = 4'd3;
	localparam logic [3:0] INF_LEN   = 4'd8;

	function automatic logic [7:0] nan_char(input logic [1:0] pos);
		logic [7:0] c;
		unique case (pos)
			2'd1:    c = "a";
			default: c = "n";
		endcase
		return c;
	endfunction

	function automatic logic [7:0] inf_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0:    c = "i";
			3'd1:    c = "n";
			3'd2:    c = "f";
			3'd3:    c = "i";
			3'd4:    c = "n";
			3'd5:    c = "i";
			3'd6:    c = "t";
			default: c = "e";
		endcase
		return c;
	endfunction

endpackage

[rtl/nll_front.sv]
`timescale 1ns / 1ps

module nll_front import nll_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   sym_valid,
	output logic   sym_stall,
	input  item_t  sym,
	input  logic   q_full,
	output qslot_t push
);

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls_d;
	logic take;
	logic is_upper;
	logic is_af;

	always_comb begin
		is_upper = (sym.ch >= 8'h41) && (sym.ch <= 8'h5A);
		cls_d.start = sym.start_req;
		cls_d.lower = is_upper ? (sym.ch + 8'd32) : sym.ch;
		cls_d.is_dec = (sym.ch >= 8'h30) && (sym.ch <= 8'h39);
		is_af = (cls_d.lower >= 8'h61) && (cls_d.lower <= 8'h66);
		cls_d.hex_ok = cls_d.is_dec || is_af;
		cls_d.dval = cls_d.is_dec ? sym.ch[3:0] : (cls_d.lower[3:0] + 4'd9);
		cls_d.is_minus = sym.ch == CH_MINUS;
		cls_d.is_plus = sym.ch == CH_PLUS;
		cls_d.is_dot = sym.ch == CH_DOT;
	end

	assign sym_stall = valid_s1 && q_full;
	assign take = sym_valid && !sym_stall;
	assign push.valid = valid_s1 && !q_full;
	assign push.cls = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push.valid) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

[rtl/nll_queue.sv]
`timescale 1ns / 1ps
`include "number_literal_lexer_top_defines.svh"

module nll_queue import nll_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  qslot_t push,
	output logic   full,
	input  logic   pop,
	output qslot_t head
);

	cls_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;

	assign full = count_q == (QAW+1)'(QDEPTH);
	assign do_push = push.valid && !full;
	assign head.valid = count_q != '0;
	assign head.cls = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cls;
		end
	end

	`NLL_ASSERT_IMP(a_count_bound, 1'b1, count_q <= (QAW+1)'(QDEPTH), "queue count exceeds depth")
	`NLL_ASSERT_NXT(a_push_counts, do_push && !pop, count_q == $past(count_q) + 1'b1, "push lost")

endmodule

[rtl/nll_back.sv]
`timescale 1ns / 1ps
`include "number_literal_lexer_top_defines.svh"

module nll_back import nll_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  qslot_t head,
	output logic   pop,
	output logic   res_valid,
	input  logic   res_stall,
	output res_t   res
);

	phase_t      phase_q;
	logic        neg_q;
	radix_t      radix_q;
	logic [63:0] acc_q;
	logic        ovf_q;
	logic [3:0]  pos_q;
	logic        res_valid_q;
	res_t        res_q;

	cls_t        c;
	logic        sign_only;
	logic        active;
	phase_t      eff_phase;
	logic        eff_neg;
	radix_t      eff_radix;
	logic [63:0] eff_acc;
	logic        eff_ovf;
	logic [3:0]  eff_pos;
	logic        dig_ok;
	logic        is_e;
	logic        nan_done;
	logic        nan_hit;
	logic        inf_done;
	logic        inf_hit;
	phase_t      phase_d;

	logic        emit;
	logic        emit_err;
	logic [3:0]  err_code;
	logic        end_int;
	logic        end_float;
	logic        act_add;
	logic        act_radix;
	radix_t      new_radix;
	logic        act_pos;
	logic [3:0]  name_err;

	logic [67:0] acc_w;
	logic [67:0] mul;
	logic [67:0] sum;
	logic        ovf_add;
	res_t        res_d;
	logic        out_free;

	always_comb begin
		c = head.cls;
		sign_only = c.start && c.is_minus;
		active = c.start ? !c.is_minus : (phase_q != PH_IDLE);
		eff_phase = c.start ? PH_SIGN : phase_q;
		eff_neg = c.start ? 1'b0 : neg_q;
		eff_radix = c.start ? RX_DEC : radix_q;
		eff_acc = c.start ? 64'd0 : acc_q;
		eff_ovf = c.start ? 1'b0 : ovf_q;
		eff_pos = c.start ? 4'd0 : pos_q;
		is_e = c.lower == CH_E;
		unique case (eff_radix)
			RX_DEC: dig_ok = c.is_dec;
			RX_BIN: dig_ok = c.hex_ok && (c.dval < 4'd2);
			RX_OCT: dig_ok = c.hex_ok && (c.dval < 4'd8);
			RX_HEX: dig_ok = c.hex_ok;
		endcase
		nan_done = eff_pos >= NAN_LEN;
		nan_hit = !nan_done && (c.lower == nan_char(eff_pos[1:0]));
		inf_done = eff_pos >= INF_LEN;
		inf_hit = !inf_done && (c.lower == inf_char(eff_pos[2:0]));
		name_err = eff_neg ? ST_MINUS : ST_DIGIT;
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (sign_only) begin
			phase_d = PH_SIGN;
		end else if (active) begin
			phase_d = PH_IDLE;
			unique case (eff_phase)
				PH_IDLE: phase_d = PH_IDLE;
				PH_SIGN: begin
					if (c.is_dec && c.dval == 4'd0) phase_d = PH_ZERO;
					else if (c.is_dec) phase_d = PH_DEC;
					else if (c.is_dot) phase_d = PH_FRAC0;
					else if (c.lower == CH_N) phase_d = PH_NAN;
					else if (c.lower == CH_I) phase_d = PH_INF;
				end
				PH_ZERO: begin
					if (c.is_dec) phase_d = PH_IDLE;
					else if (c.lower == CH_B || c.lower == CH_O || c.lower == CH_X)
						phase_d = PH_PFX;
					else if (c.is_dot) phase_d = PH_FRAC;
					else if (is_e) phase_d = PH_EXP;
				end
				PH_PFX, PH_PDIG: begin
					if (dig_ok) phase_d = PH_PDIG;
				end
				PH_DEC: begin
					if (c.is_dec) phase_d = PH_DEC;
					else if (c.is_dot) phase_d = PH_FRAC;
					else if (is_e) phase_d = PH_EXP;
				end
				PH_FRAC0: begin
					if (c.is_dec) phase_d = PH_FRAC;
					else if (is_e) phase_d = PH_EXP0;
				end
				PH_FRAC: begin
					if (c.is_dec) phase_d = PH_FRAC;
					else if (is_e) phase_d = PH_EXP;
				end
				PH_EXP: begin
					if (c.is_plus || c.is_minus) phase_d = PH_ESGN;
					else if (c.is_dec) phase_d = PH_EDIG;
				end
				PH_EXP0: begin
					if (c.is_plus || c.is_minus) phase_d = PH_ESGN0;
					else if (c.is_dec) phase_d = PH_EDIG0;
				end
				PH_ESGN, PH_EDIG: begin
					if (c.is_dec) phase_d = PH_EDIG;
				end
				PH_ESGN0, PH_EDIG0: begin
					if (c.is_dec) phase_d = PH_EDIG0;
				end
				PH_NAN: begin
					if (nan_hit) phase_d = PH_NAN;
				end
				PH_INF: begin
					if (inf_hit) phase_d = PH_INF;
				end
			endcase
		end
	end

	// Actions and results.
	always_comb begin
		emit_err = 1'b0;
		err_code = ST_OK;
		end_int = 1'b0;
		end_float = 1'b0;
		act_add = 1'b0;
		act_radix = 1'b0;
		new_radix = RX_DEC;
		act_pos = 1'b0;
		if (active) begin
			unique case (eff_phase)
				PH_IDLE: ;
				PH_SIGN: begin
					if (c.is_dec && c.dval != 4'd0) act_add = 1'b1;
					else if (c.is_dec || c.is_dot) ;
					else if (c.lower == CH_N || c.lower == CH_I) act_pos = 1'b1;
					else begin
						emit_err = 1'b1;
						err_code = name_err;
					end
				end
				PH_ZERO: begin
					if (c.is_dec) begin
						emit_err = 1'b1;
						err_code = ST_LEADZ;
					end else if (c.lower == CH_B) begin
						act_radix = 1'b1;
						new_radix = RX_BIN;
					end else if (c.lower == CH_O) begin
						act_radix = 1'b1;
						new_radix = RX_OCT;
					end else if (c.lower == CH_X) begin
						act_radix = 1'b1;
						new_radix = RX_HEX;
					end else if (!(c.is_dot || is_e)) begin
						end_int = 1'b1;
					end
				end
				PH_PFX: begin
					if (dig_ok) act_add = 1'b1;
					else begin
						emit_err = 1'b1;
						err_code = 4'(eff_radix) + 4'd1;
					end
				end
				PH_PDIG: begin
					if (dig_ok) act_add = 1'b1;
					else end_int = 1'b1;
				end
				PH_DEC: begin
					if (c.is_dec) act_add = 1'b1;
					else if (!(c.is_dot || is_e)) end_int = 1'b1;
				end
				PH_FRAC0, PH_EDIG0: begin
					if (!(c.is_dec || (is_e && eff_phase == PH_FRAC0))) begin
						emit_err = 1'b1;
						err_code = ST_DIGIT;
					end
				end
				PH_FRAC: begin
					if (!(c.is_dec || is_e)) end_float = 1'b1;
				end
				PH_EXP, PH_EXP0: begin
					if (!(c.is_dec || c.is_plus || c.is_minus)) begin
						emit_err = 1'b1;
						err_code = ST_EXP;
					end
				end
				PH_ESGN, PH_ESGN0: begin
					if (!c.is_dec) begin
						emit_err = 1'b1;
						err_code = ST_EXP;
					end
				end
				PH_EDIG: begin
					if (!c.is_dec) end_float = 1'b1;
				end
				PH_NAN: begin
					if (nan_done) end_float = 1'b1;
					else if (nan_hit) act_pos = 1'b1;
					else begin
						emit_err = 1'b1;
						err_code = name_err;
					end
				end
				PH_INF: begin
					if (inf_done) end_float = 1'b1;
					else if (inf_hit) act_pos = 1'b1;
					else if (eff_pos >= INF_SHORT) end_float = 1'b1;
					else begin
						emit_err = 1'b1;
						err_code = name_err;
					end
				end
			endcase
		end
		emit = emit_err || end_int || end_float;
	end

	always_comb begin
		acc_w = {4'd0, eff_acc};
		unique case (eff_radix)
			RX_DEC: mul = (acc_w << 3) + (acc_w << 1);
			RX_BIN: mul = acc_w << 1;
			RX_OCT: mul = acc_w << 3;
			RX_HEX: mul = acc_w << 4;
		endcase
		sum = mul + {64'd0, c.dval};
		ovf_add = |sum[67:64];
	end

	always_comb begin
		res_d.status = ST_OK;
		res_d.kind = KIND_INVALID;
		res_d.value = 64'd0;
		if (emit_err) begin
			res_d.status = err_code;
		end else if (end_float) begin
			res_d.kind = KIND_FLOAT;
		end else if (eff_ovf || (eff_neg && eff_acc[63] && (|eff_acc[62:0]))) begin
			res_d.status = ST_RANGE;
		end else if (eff_neg) begin
			res_d.kind = KIND_SIGNED;
			res_d.value = 64'd0 - eff_acc;
		end else begin
			res_d.kind = KIND_UNSIGNED;
			res_d.value = eff_acc;
		end
	end

	assign out_free = !res_valid_q || !res_stall;
	assign pop = head.valid && (!emit || out_free);
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q <= 1'b0;
			radix_q <= RX_DEC;
			acc_q <= 64'd0;
			ovf_q <= 1'b0;
			pos_q <= 4'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				neg_q <= sign_only ? 1'b1 : eff_neg;
				radix_q <= act_radix ? new_radix : eff_radix;
				acc_q <= act_add ? sum[63:0] : eff_acc;
				ovf_q <= eff_ovf || (act_add && ovf_add);
				pos_q <= eff_pos + {3'd0, act_pos};
			end
			if (pop && emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= res_d;
		end
	end

	`NLL_ASSERT_IMP(a_kind_status, res_valid_q, (res_q.kind == KIND_INVALID) == (res_q.status != ST_OK), "kind and status disagree")
	`NLL_ASSERT_NXT(a_emit_idles, pop && emit, phase_q == PH_IDLE, "token not closed after result")

endmodule

[rtl/number_literal_lexer_top.sv]
`timescale 1ns / 1ps

// Streaming numeric literal lexer. One character is taken per cycle on the sym channel when
// nothing stalls, a rate set by the back end's state and shift-and-add accumulator update, with
// start_req marking the first character of a token; one result leaves on the res channel when
// a token ends or fails. A character is registered in the front end and the queue, its result
// in the back end's result register. A four-entry queue between the classifying front end and
// the back end keeps characters flowing while a result waits.
module number_literal_lexer_top import nll_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  sym_valid,
	output logic  sym_stall,
	input  item_t sym,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	qslot_t push;
	qslot_t head;
	logic   q_full;
	logic   pop;

	nll_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym       (sym),
		.q_full    (q_full),
		.push      (push)
	);

	nll_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	nll_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
